// ===== rtl/core/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH   = 32;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int CLASS_W       = 4;
  localparam int PREC_W        = 4;
  localparam int STATUS_W      = 2;
  localparam int NUM_REGS      = 7;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W         = $clog2(STACK_DEPTH);

  // token classes
  localparam logic [CLASS_W-1:0] CLS_OPERAND = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_PLUS    = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_MINUS   = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_MULT    = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_DIV     = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_EXP     = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_LPAREN  = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_RPAREN  = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_SIN     = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_COS     = 4'd9;
  localparam logic [CLASS_W-1:0] CLS_TAN     = 4'd10;
  localparam logic [CLASS_W-1:0] CLS_SQRT    = 4'd11;
  localparam logic [CLASS_W-1:0] CLS_LN      = 4'd12;
  localparam logic [CLASS_W-1:0] CLS_END     = 4'd13;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNMATCH  = 2'd3;

  // precedence register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LPAREN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FUNC   = 3'd6;

  typedef logic [NUM_REGS-1:0][PREC_W-1:0] prec_bank_t;

  localparam prec_bank_t PREC_RESET = {4'd4, 4'd0, 4'd3, 4'd2, 4'd2, 4'd1, 4'd1};

  typedef struct packed {
    logic [CLASS_W-1:0]       cls;
    logic [PAYLOAD_WIDTH-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } stk_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    entry_t           top;
  } stk_stat_t;

endpackage

// ===== rtl/core/itp_stack.sv =====
`timescale 1ns / 1ps

module itp_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  itp_pkg::stk_cmd_t cmd,
  output itp_pkg::stk_stat_t stat
);
  import itp_pkg::*;

  entry_t           mem [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] rd_cnt;
  entry_t           top_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    // address of the entry that will be on top next cycle
    rd_cnt = cnt_nxt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[PTR_W-1:0]] <= cmd.wdata;
    end
  end

  // registered top read, with bypass when the pushed word becomes the top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= cmd.wdata;
    end else begin
      top_r <= mem[rd_cnt[PTR_W-1:0]];
    end
  end

  assign stat.count = cnt_r;
  assign stat.top   = top_r;

endmodule

// ===== rtl/core/infix_to_postfix_reorder_unit.sv =====
`timescale 1ns / 1ps

// Reorders a stream of scanned tokens into postfix order with an operator stack of
// STACK_DEPTH entries held in a memory with a registered top-of-stack read. One token
// is taken at a time: in_stall stays high until every word it causes has been handed
// to the output register. A single precedence lookup and compare unit is shared by
// the incoming token and each popped entry, one pop per cycle while the held word can
// move on. Every word but the last of a token goes out with out_last low and status ok;
// an error gives one closing word with out_class 0 and the token's payload. The
// precedence registers must only be written while the block is idle.
module infix_to_postfix_reorder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [itp_pkg::CLASS_W-1:0]          in_token_class,
  input  logic [itp_pkg::PAYLOAD_WIDTH-1:0]    in_token_payload,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [itp_pkg::CLASS_W-1:0]          out_class,
  output logic [itp_pkg::PAYLOAD_WIDTH-1:0]    out_payload,
  output logic                                 out_last,
  output logic [itp_pkg::STATUS_W-1:0]         out_status,
  input  logic                                 cfg_we,
  input  logic [itp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [itp_pkg::PREC_W-1:0]           cfg_data
);
  import itp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [CLASS_W-1:0] c,
                                                 input prec_bank_t b);
    logic [PREC_W-1:0] p;
    p = '0;
    unique case (c)
      CLS_PLUS:   p = b[REG_PLUS];
      CLS_MINUS:  p = b[REG_MINUS];
      CLS_MULT:   p = b[REG_MULT];
      CLS_DIV:    p = b[REG_DIV];
      CLS_EXP:    p = b[REG_EXP];
      CLS_LPAREN: p = b[REG_LPAREN];
      CLS_SIN, CLS_COS, CLS_TAN, CLS_SQRT, CLS_LN: p = b[REG_FUNC];
      default:    p = '0;
    endcase
    return p;
  endfunction

  state_t state_r, state_nxt;
  prec_bank_t prec_r;

  logic [CLASS_W-1:0]       cls_r, cls_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;
  logic [PREC_W-1:0]        prec_cur_r, prec_cur_nxt;

  logic                     hold_v_r, hold_v_nxt;
  entry_t                   hold_r, hold_nxt;
  logic [STATUS_W-1:0]      hold_st_r, hold_st_nxt;

  logic                     out_valid_r, out_valid_nxt;
  entry_t                   out_word_r, out_word_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;

  stk_cmd_t  cmd;
  stk_stat_t stat;

  logic [CLASS_W-1:0] lookup_cls;
  logic [PREC_W-1:0]  prec_lk;
  logic               stack_empty, stack_full, stack_one;
  logic               out_free, emit_ok;
  logic               is_oper, is_pushonly;
  logic               new_v, done;
  entry_t             new_word;
  logic [STATUS_W-1:0] new_st;

  itp_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  // one lookup port: the arriving token while idle, the stack top while running
  assign lookup_cls  = (state_r == S_IDLE) ? in_token_class : stat.top.cls;
  assign prec_lk     = prec_of(lookup_cls, prec_r);

  assign stack_empty = (stat.count == '0);
  assign stack_full  = (stat.count == CNT_W'(STACK_DEPTH));
  assign stack_one   = (stat.count == CNT_W'(1));
  assign out_free    = !out_valid_r || !out_stall;
  assign emit_ok     = !hold_v_r || out_free;

  assign is_oper     = (cls_r >= CLS_PLUS) && (cls_r <= CLS_EXP);
  assign is_pushonly = (cls_r == CLS_LPAREN) || ((cls_r >= CLS_SIN) && (cls_r <= CLS_LN));

  always_comb begin
    state_nxt      = state_r;
    cls_nxt        = cls_r;
    pay_nxt        = pay_r;
    prec_cur_nxt   = prec_cur_r;
    hold_v_nxt     = hold_v_r;
    hold_nxt       = hold_r;
    hold_st_nxt    = hold_st_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    new_v          = 1'b0;
    new_word       = '{cls: CLS_OPERAND, pay: pay_r};
    new_st         = ST_OK;
    done           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cls_nxt      = in_token_class;
          pay_nxt      = in_token_payload;
          prec_cur_nxt = prec_lk;
          state_nxt    = S_RUN;
        end
      end
      S_RUN: begin
        priority if (cls_r == CLS_OPERAND) begin
          new_v = 1'b1;
          done  = 1'b1;
        end else if (is_oper || is_pushonly) begin
          if (is_oper && !stack_empty && (prec_lk >= prec_cur_r)) begin
            new_v    = 1'b1;
            new_word = stat.top;
            cmd.pop  = 1'b1;
          end else if (!stack_full) begin
            cmd.push  = 1'b1;
            cmd.wdata = '{cls: cls_r, pay: pay_r};
            done      = 1'b1;
          end else begin
            new_v  = 1'b1;
            new_st = ST_OVERFLOW;
            done   = 1'b1;
          end
        end else if (cls_r == CLS_RPAREN) begin
          priority if (stack_empty) begin
            new_v  = 1'b1;
            new_st = ST_UNMATCH;
            done   = 1'b1;
          end else if (stat.top.cls == CLS_LPAREN) begin
            cmd.pop = 1'b1;
            done    = 1'b1;
          end else if (stack_one) begin
            // bottom entry is dropped and the error word closes the token
            cmd.pop = 1'b1;
            new_v   = 1'b1;
            new_st  = ST_UNMATCH;
            done    = 1'b1;
          end else begin
            new_v    = 1'b1;
            new_word = stat.top;
            cmd.pop  = 1'b1;
          end
        end else if (cls_r == CLS_END) begin
          if (!stack_empty) begin
            new_v    = 1'b1;
            new_word = stat.top;
            cmd.pop  = 1'b1;
          end else begin
            new_v    = 1'b1;
            new_word = '{cls: CLS_END, pay: pay_r};
            done     = 1'b1;
          end
        end else begin
          new_v  = 1'b1;
          new_st = ST_UNKNOWN;
          done   = 1'b1;
        end

        // wait while the held word cannot move on
        if (new_v && !emit_ok) begin
          cmd   = '0;
          new_v = 1'b0;
          done  = 1'b0;
        end

        if (new_v) begin
          if (hold_v_r) begin
            out_valid_nxt  = 1'b1;
            out_word_nxt   = hold_r;
            out_last_nxt   = 1'b0;
            out_status_nxt = hold_st_r;
          end
          hold_v_nxt  = 1'b1;
          hold_nxt    = new_word;
          hold_st_nxt = new_st;
        end
        if (done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = hold_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = hold_st_r;
          hold_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cls_r        <= cls_nxt;
    pay_r        <= pay_nxt;
    prec_cur_r   <= prec_cur_nxt;
    hold_r       <= hold_nxt;
    hold_st_r    <= hold_st_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      prec_r[cfg_index] <= cfg_data;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_class   = out_word_r.cls;
  assign out_payload = out_word_r.pay;
  assign out_last    = out_last_r;
  assign out_status  = out_status_r;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stack_full)
    else $error("push onto full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stack_empty)
    else $error("pop from empty stack");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count out of range");

  a_mid_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("error status on a word that is not last");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("held word left behind when idle");

endmodule

// ===== verif/tb_infix_to_postfix_reorder_unit.sv =====
`timescale 1ns / 1ps

module tb_infix_to_postfix_reorder_unit;
  import itp_pkg::*;

  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 4'd14;
  localparam logic [CLASS_W-1:0] CLS_SPARE   = 4'd15;
  localparam int PHASE_TOKENS = 47;
  localparam int SETTLE       = 12;

  typedef struct packed {
    logic [CLASS_W-1:0]       cls;
    logic [PAYLOAD_WIDTH-1:0] pay;
    logic                     last;
    logic [STATUS_W-1:0]      status;
  } word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CLASS_W-1:0]       in_token_class = '0;
  logic [PAYLOAD_WIDTH-1:0] in_token_payload = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CLASS_W-1:0]       out_class;
  logic [PAYLOAD_WIDTH-1:0] out_payload;
  logic                     out_last;
  logic [STATUS_W-1:0]      out_status;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [PREC_W-1:0]        cfg_data = '0;

  infix_to_postfix_reorder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_token_class   (in_token_class),
    .in_token_payload (in_token_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_class        (out_class),
    .out_payload      (out_payload),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // tokens waiting to be sent and postfix words still owed by the block
  entry_t token_q[$];
  word_t  postfix_q[$];
  int     sent_cnt = 0;
  int     acc_cnt = 0;
  int     err_cnt = 0;

  // shadow of the block's precedence registers and operator stack
  logic [PREC_W-1:0] prec_q[NUM_REGS];
  entry_t            op_stack[STACK_DEPTH];
  int                stk_cnt = 0;

  initial begin
    for (int i = 0; i < NUM_REGS; i++) prec_q[i] = PREC_RESET[i];
  end

  function automatic logic [PREC_W-1:0] prec_of(input logic [CLASS_W-1:0] c);
    case (c)
      CLS_PLUS:   return prec_q[REG_PLUS];
      CLS_MINUS:  return prec_q[REG_MINUS];
      CLS_MULT:   return prec_q[REG_MULT];
      CLS_DIV:    return prec_q[REG_DIV];
      CLS_EXP:    return prec_q[REG_EXP];
      CLS_LPAREN: return prec_q[REG_LPAREN];
      CLS_SIN, CLS_COS, CLS_TAN, CLS_SQRT, CLS_LN: return prec_q[REG_FUNC];
      default:    return '0;
    endcase
  endfunction

  function automatic void add_word(input logic [CLASS_W-1:0] c,
                                   input logic [PAYLOAD_WIDTH-1:0] p,
                                   input logic [STATUS_W-1:0] st);
    word_t w;
    w.cls = c;
    w.pay = p;
    w.last = 1'b0;
    w.status = st;
    postfix_q.push_back(w);
  endfunction

  function automatic void pop_word();
    stk_cnt--;
    add_word(op_stack[stk_cnt].cls, op_stack[stk_cnt].pay, ST_OK);
  endfunction

  function automatic bit push_entry(input logic [CLASS_W-1:0] c,
                                    input logic [PAYLOAD_WIDTH-1:0] p);
    if (stk_cnt >= STACK_DEPTH) return 1'b0;
    op_stack[stk_cnt].cls = c;
    op_stack[stk_cnt].pay = p;
    stk_cnt++;
    return 1'b1;
  endfunction

  // work out the postfix words one accepted token causes
  function automatic void reorder_token(input logic [CLASS_W-1:0] c,
                                        input logic [PAYLOAD_WIDTH-1:0] p);
    int                n0;
    bit                found;
    bit                done;
    logic [PREC_W-1:0] pr;
    word_t             w;
    n0 = postfix_q.size();
    case (c)
      CLS_OPERAND: add_word(CLS_OPERAND, p, ST_OK);
      CLS_PLUS, CLS_MINUS, CLS_MULT, CLS_DIV, CLS_EXP: begin
        pr = prec_of(c);
        while (stk_cnt > 0 && prec_of(op_stack[stk_cnt-1].cls) >= pr) pop_word();
        if (!push_entry(c, p)) add_word(CLS_OPERAND, p, ST_OVERFLOW);
      end
      CLS_LPAREN, CLS_SIN, CLS_COS, CLS_TAN, CLS_SQRT, CLS_LN: begin
        if (!push_entry(c, p)) add_word(CLS_OPERAND, p, ST_OVERFLOW);
      end
      CLS_RPAREN: begin
        found = 1'b0;
        done = 1'b0;
        while (stk_cnt > 0 && !done) begin
          if (op_stack[stk_cnt-1].cls == CLS_LPAREN) begin
            stk_cnt--;
            found = 1'b1;
            done = 1'b1;
          end else if (stk_cnt == 1) begin
            // bottom entry is dropped, not emitted
            stk_cnt = 0;
            done = 1'b1;
          end else begin
            pop_word();
          end
        end
        if (!found) add_word(CLS_OPERAND, p, ST_UNMATCH);
      end
      CLS_END: begin
        while (stk_cnt > 0) pop_word();
        add_word(CLS_END, p, ST_OK);
      end
      default: add_word(CLS_OPERAND, p, ST_UNKNOWN);
    endcase
    if (postfix_q.size() > n0) begin
      w = postfix_q.pop_back();
      w.last = 1'b1;
      postfix_q.push_back(w);
    end
  endfunction

  // driver: bursts of tokens with random gaps
  int     burst_left = 0;
  int     gap_left = 0;
  entry_t tok;

  always @(negedge clk) begin
    if (rst_n && sent_cnt == acc_cnt) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (token_q.size() > 0) begin
        tok = token_q.pop_front();
        in_token_class <= tok.cls;
        in_token_payload <= tok.pay;
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with the mode picked anew when its run counter expires
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ((stall_left % 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // monitor: input side feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      reorder_token(in_token_class, in_token_payload);
      acc_cnt <= acc_cnt + 1;
    end
  end

  // monitor: output side checks each word against the oldest expectation
  word_t exp_w;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (postfix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected word: class %0d payload %h last %b status %0d",
                   out_class, out_payload, out_last, out_status);
      end else begin
        exp_w = postfix_q.pop_front();
        if (exp_w.cls !== out_class || exp_w.pay !== out_payload ||
            exp_w.last !== out_last || exp_w.status !== out_status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp class %0d payload %h last %b status %0d, %s %0d %h %b %0d",
                     exp_w.cls, exp_w.pay, exp_w.last, exp_w.status, "got",
                     out_class, out_payload, out_last, out_status);
        end
      end
    end
  end

  function automatic logic [PAYLOAD_WIDTH-1:0] rand_pay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PAYLOAD_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] rand_binop();
    case ($urandom_range(0, 4))
      0:       return CLS_PLUS;
      1:       return CLS_MINUS;
      2:       return CLS_MULT;
      3:       return CLS_DIV;
      default: return CLS_EXP;
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] rand_func();
    case ($urandom_range(0, 4))
      0:       return CLS_SIN;
      1:       return CLS_COS;
      2:       return CLS_TAN;
      3:       return CLS_SQRT;
      default: return CLS_LN;
    endcase
  endfunction

  function automatic void put_tok(input logic [CLASS_W-1:0] c,
                                  input logic [PAYLOAD_WIDTH-1:0] p);
    entry_t e;
    e.cls = c;
    e.pay = p;
    token_q.push_back(e);
  endfunction

  // well-formed infix expression with random shape
  function automatic void gen_expr(input int lvl);
    int k;
    k = (lvl >= 3) ? 0 : $urandom_range(0, 5);
    case (k)
      2, 3: begin
        gen_expr(lvl + 1);
        put_tok(rand_binop(), rand_pay());
        gen_expr(lvl + 1);
      end
      4: begin
        put_tok(CLS_LPAREN, rand_pay());
        gen_expr(lvl + 1);
        put_tok(CLS_RPAREN, rand_pay());
      end
      5: begin
        put_tok(rand_func(), rand_pay());
        put_tok(CLS_LPAREN, rand_pay());
        gen_expr(lvl + 1);
        put_tok(CLS_RPAREN, rand_pay());
      end
      default: put_tok(CLS_OPERAND, rand_pay());
    endcase
  endfunction

  // deep nesting; functions among the openers leave closers unmatched
  function automatic void gen_deep(input int n, input bit paren_only);
    for (int i = 0; i < n; i++) begin
      if (paren_only || $urandom_range(0, 3) != 0) put_tok(CLS_LPAREN, rand_pay());
      else put_tok(rand_func(), rand_pay());
    end
    put_tok(CLS_OPERAND, rand_pay());
    for (int i = 0; i < n; i++) put_tok(CLS_RPAREN, rand_pay());
    put_tok(CLS_END, rand_pay());
  endfunction

  function automatic void fill_random(input int cnt);
    int                 k;
    logic [CLASS_W-1:0] c;
    while (token_q.size() < cnt) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        gen_expr(0);
        repeat ($urandom_range(0, 2)) begin
          put_tok(rand_binop(), rand_pay());
          gen_expr(0);
        end
        put_tok(CLS_END, rand_pay());
      end else if (k == 7) begin
        gen_deep($urandom_range(2, 12), 1'b0);
      end else begin
        repeat ($urandom_range(2, 8)) begin
          c = CLASS_W'($urandom_range(0, 15));
          put_tok(c, rand_pay());
        end
        if ($urandom_range(0, 1) == 0) put_tok(CLS_END, rand_pay());
      end
    end
    put_tok(CLS_END, rand_pay());
  endfunction

  task automatic wait_idle();
    while (token_q.size() != 0 || sent_cnt != acc_cnt || postfix_q.size() != 0)
      @(posedge clk);
    // a quiet token may still be in the block
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [PREC_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= v;
    prec_q[idx] = v;
  endtask

  initial begin
    logic [PREC_W-1:0] v;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with reset precedences
    put_tok(CLS_OPERAND, '0);
    put_tok(CLS_OPERAND, '1);
    put_tok(CLS_UNKNOWN, 16'h1234);
    put_tok(CLS_SPARE, '1);
    put_tok(CLS_RPAREN, 16'h00ff);     // empty stack
    put_tok(CLS_OPERAND, 16'h0a0a);
    put_tok(CLS_PLUS, 16'h0001);
    put_tok(CLS_OPERAND, 16'h0b0b);
    put_tok(CLS_MULT, 16'h0003);
    put_tok(CLS_OPERAND, 16'h0c0c);
    put_tok(CLS_EXP, 16'h0005);
    put_tok(CLS_OPERAND, 16'h0d0d);
    put_tok(CLS_DIV, 16'h0004);
    put_tok(CLS_LPAREN, 16'h0006);
    put_tok(CLS_OPERAND, 16'h0e0e);
    put_tok(CLS_MINUS, 16'h0002);
    put_tok(CLS_OPERAND, 16'h0f0f);
    put_tok(CLS_RPAREN, 16'h0007);
    put_tok(CLS_SIN, 16'h0008);
    put_tok(CLS_LPAREN, 16'h0016);
    put_tok(CLS_RPAREN, 16'h0017);     // matching paren right on top
    put_tok(CLS_COS, 16'h0009);
    put_tok(CLS_TAN, 16'h000a);
    put_tok(CLS_SQRT, 16'h000b);
    put_tok(CLS_LN, 16'h000c);
    put_tok(CLS_END, 16'hffee);
    put_tok(CLS_PLUS, 16'h1001);
    put_tok(CLS_MULT, 16'h1003);
    put_tok(CLS_RPAREN, 16'h1007);     // runs out, bottom entry dropped
    put_tok(CLS_END, 16'h100d);        // end on empty stack
    // one level past the stack depth
    gen_deep(STACK_DEPTH + 1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      for (int r = 0; r < NUM_REGS; r++) begin
        case (ph)
          0:       v = '0;
          1:       v = '1;
          default: v = PREC_W'($urandom_range(0, 15));
        endcase
        // left paren that pops like an operator
        if (ph == 2 && r == REG_LPAREN) v = '1;
        write_reg(r, v);
      end
      @(negedge clk);
      cfg_we <= 1'b0;
      fill_random(PHASE_TOKENS);
    end

    while (token_q.size() != 0 || sent_cnt != acc_cnt || postfix_q.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && postfix_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== infix_to_postfix_reorder_unit.f =====
rtl/core/itp_pkg.sv
rtl/core/itp_stack.sv
rtl/core/infix_to_postfix_reorder_unit.sv
verif/tb_infix_to_postfix_reorder_unit.sv
